/* rtl/irbf_pkg.sv */
// ----------------------------------------------------------------------------
// irbf_pkg
// shared types, action codes and octet range compare for the blocklist filter
// ----------------------------------------------------------------------------
package irbf_pkg;

    localparam int OCTETS   = 4;
    localparam int OCTET_W  = 8;
    localparam int ADDR_W   = OCTETS * OCTET_W;
    localparam int ACTION_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   addr_low;
        logic [ADDR_W-1:0]   addr_high;
    } t_in_item;

    typedef struct packed {
        logic allowed;
        logic status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

    function automatic logic octets_match(
        input logic [ADDR_W-1:0] lo,
        input logic [ADDR_W-1:0] hi,
        input logic [ADDR_W-1:0] addr
    );
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < OCTETS; k++) begin
            if (addr[k*OCTET_W +: OCTET_W] < lo[k*OCTET_W +: OCTET_W] ||
                addr[k*OCTET_W +: OCTET_W] > hi[k*OCTET_W +: OCTET_W]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/irbf_ctrl.sv */
// ----------------------------------------------------------------------------
// irbf_ctrl
// sequencer: accepts a command beat, runs the table sweep for insert and check, then finishes
// ----------------------------------------------------------------------------
module irbf_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [irbf_pkg::ACTION_W-1:0]      i_action,
    input  irbf_pkg::t_sts                     i_sts,
    output logic                               busy,
    output irbf_pkg::t_cmd                     o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_action == irbf_pkg::ACT_INSERT ||
                        i_action == irbf_pkg::ACT_CHECK) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_finish_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> ($past(r_state) == ST_SCAN || $past(accept)))
        else $error("finish entered without a command or sweep");

    a_idle_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> (r_state == ST_IDLE))
        else $error("finish did not return to idle");

    a_scan_leaves_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.scan_done) |=> (r_state == ST_FINISH))
        else $error("sweep completion missed");

endmodule

/* rtl/irbf_datapath.sv */
// ----------------------------------------------------------------------------
// irbf_datapath
// entry table, sweep pointer, single comparator and result register
// ----------------------------------------------------------------------------
module irbf_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irbf_pkg::t_in_item    i_item,
    input  irbf_pkg::t_cmd        i_cmd,
    output irbf_pkg::t_sts        o_sts,
    output logic                  o_done,
    output irbf_pkg::t_out_item   o_result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AW    = irbf_pkg::ADDR_W;

    logic [2*AW-1:0]              mem [TABLE_DEPTH];
    logic [2*AW-1:0]              r_rd_data;
    logic                         r_pend;
    logic [CNT_W-1:0]             r_idx;
    logic [CNT_W-1:0]             r_count;
    logic                         r_hit;
    logic [irbf_pkg::ACTION_W-1:0] r_action;
    logic [AW-1:0]                r_lo;
    logic [AW-1:0]                r_hi;
    logic                         r_done;
    irbf_pkg::t_out_item          r_result;

    logic [AW-1:0] rd_lo;
    logic [AW-1:0] rd_hi;
    logic          cmp_hit;
    logic          more;
    logic          issue;
    logic          full;
    logic          do_write;

    assign rd_lo = r_rd_data[2*AW-1:AW];
    assign rd_hi = r_rd_data[AW-1:0];

    always_comb begin
        if (r_action == irbf_pkg::ACT_INSERT) begin
            cmp_hit = (rd_lo == r_lo) && (rd_hi == r_hi);
        end else begin
            cmp_hit = irbf_pkg::octets_match(rd_lo, rd_hi, r_lo);
        end
    end

    assign more     = (r_idx < r_count) && !r_hit;
    assign issue    = i_cmd.scan && more && !(r_pend && cmp_hit);
    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign do_write = i_cmd.finish && (r_action == irbf_pkg::ACT_INSERT) && !r_hit && !full;

    assign o_sts.scan_done = !r_pend && !more;

    // table storage
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[r_count[IDX_W-1:0]] <= {r_lo, r_hi};
        end
        if (issue) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
    end

    // captured command beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_lo     <= i_item.addr_low;
            r_hi     <= i_item.addr_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_pend <= 1'b0;
                r_idx  <= '0;
                r_hit  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (r_pend && cmp_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_action == irbf_pkg::ACT_CLEAR) begin
                    r_count <= '0;
                end else if (do_write) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.allowed <= !((r_action == irbf_pkg::ACT_CHECK) && r_hit);
            r_result.status  <= (r_action == irbf_pkg::ACT_INSERT) && !r_hit && full;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pend_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cmd.scan))
        else $error("read in flight outside a sweep");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one beat");

    a_count_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(i_cmd.finish))
        else $error("entry count changed outside finish");

endmodule

/* rtl/ipv4_range_blocklist_filter_core.sv */
// ----------------------------------------------------------------------------
// ipv4_range_blocklist_filter_core
// ipv4 range blocklist: clear, insert and check against up to TABLE_DEPTH entries
// clear or unused code skips the sweep; insert or check sweep the stored entries,
// stopping early on a hit
// throughput: next beat accepted in the cycle the result strobe is shown
// reset clears the entry count and control; table contents are left as is
// results are strobed for one cycle and cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module ipv4_range_blocklist_filter_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  irbf_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_done,
    output irbf_pkg::t_out_item   o_result
);

    irbf_pkg::t_cmd cmd;
    irbf_pkg::t_sts sts;

    irbf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_sts    (sts),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    irbf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

/* sim/ipv4_range_blocklist_filter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_range_blocklist_filter_core_tb
// Self-checking bench for the IPv4 range blocklist filter. A scoreboard keeps
// its own copy of the entry table. It predicts the verdict and status of each
// accepted command beat and compares every strobed result against the oldest
// prediction. The stimulus starts with a directed pass: empty table checks,
// single-address and inverted entries, duplicate inserts, filling the table
// to overflow, and clear. Random traffic then runs under three sender idle
// profiles. Most of it is entry fills and checks aimed inside inserted ranges.
// ----------------------------------------------------------------------------
module ipv4_range_blocklist_filter_core_tb;

    localparam int TABLE_DEPTH = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT = 2000;

    class blocklist_scoreboard;
        logic [irbf_pkg::ADDR_W-1:0] lo_tab [TABLE_DEPTH];
        logic [irbf_pkg::ADDR_W-1:0] hi_tab [TABLE_DEPTH];
        int unsigned                 n_entries;
        irbf_pkg::t_out_item         verdict_q [$];
        int unsigned                 n_errors;

        function new();
            n_entries = 0;
            n_errors  = 0;
        endfunction

        function automatic bit range_hit(logic [irbf_pkg::ADDR_W-1:0] lo,
                                         logic [irbf_pkg::ADDR_W-1:0] hi,
                                         logic [irbf_pkg::ADDR_W-1:0] addr);
            logic [irbf_pkg::OCTET_W-1:0] a, l, h;
            for (int k = 0; k < irbf_pkg::OCTETS; k++) begin
                a = addr[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W];
                l = lo[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W];
                h = hi[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W];
                if (a < l || a > h) return 1'b0;
            end
            return 1'b1;
        endfunction

        function automatic irbf_pkg::t_out_item apply_beat(irbf_pkg::t_in_item it);
            irbf_pkg::t_out_item res;
            bit                  dup;
            res.allowed = 1'b1;
            res.status  = 1'b0;
            dup = 1'b0;
            case (it.action)
                irbf_pkg::ACT_CLEAR: begin
                    n_entries = 0;
                end
                irbf_pkg::ACT_INSERT: begin
                    for (int i = 0; i < n_entries; i++) begin
                        if (lo_tab[i] == it.addr_low && hi_tab[i] == it.addr_high) dup = 1'b1;
                    end
                    if (!dup) begin
                        if (n_entries < TABLE_DEPTH) begin
                            lo_tab[n_entries] = it.addr_low;
                            hi_tab[n_entries] = it.addr_high;
                            n_entries++;
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                end
                irbf_pkg::ACT_CHECK: begin
                    for (int i = 0; i < n_entries; i++) begin
                        if (range_hit(lo_tab[i], hi_tab[i], it.addr_low)) res.allowed = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            return res;
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            n_errors++;
        endtask

        function void note_item(irbf_pkg::t_in_item it);
            verdict_q.push_back(apply_beat(it));
        endfunction

        task check_result(irbf_pkg::t_out_item got);
            irbf_pkg::t_out_item exp;
            if (verdict_q.size() == 0) begin
                report($sformatf("result beat with nothing pending (allowed %0b status %0b)",
                                 got.allowed, got.status));
            end else begin
                exp = verdict_q.pop_front();
                if (got.allowed !== exp.allowed)
                    report($sformatf("allowed got %b exp %b", got.allowed, exp.allowed));
                if (got.status !== exp.status)
                    report($sformatf("status got %b exp %b", got.status, exp.status));
            end
        endtask

        task check_drained();
            if (verdict_q.size() != 0)
                report($sformatf("%0d results never arrived", verdict_q.size()));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    irbf_pkg::t_in_item  cmd_beat = '0;
    logic                busy;
    logic                o_done;
    irbf_pkg::t_out_item result_beat;

    blocklist_scoreboard sb = new();

    int unsigned                 idle_pct;
    logic [irbf_pkg::ADDR_W-1:0] seen_lo [$];
    logic [irbf_pkg::ADDR_W-1:0] seen_hi [$];

    always #1 i_clk = ~i_clk;

    ipv4_range_blocklist_filter_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (cmd_beat),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (result_beat)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(result_beat);
            if (start && !busy) sb.note_item(cmd_beat);
        end
    end

    task send_beat(logic [irbf_pkg::ACTION_W-1:0] act, logic [irbf_pkg::ADDR_W-1:0] lo,
                   logic [irbf_pkg::ADDR_W-1:0] hi);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start              <= 1'b1;
        cmd_beat.action    <= act;
        cmd_beat.addr_low  <= lo;
        cmd_beat.addr_high <= hi;
        do @(posedge i_clk); while (busy);
    endtask

    task make_range(output logic [irbf_pkg::ADDR_W-1:0] lo,
                    output logic [irbf_pkg::ADDR_W-1:0] hi);
        int unsigned r, l, h;
        for (int k = 0; k < irbf_pkg::OCTETS; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                l = 0;
                h = 255;
            end else if (r < 14) begin
                l = $urandom_range(255, 1);
                h = $urandom_range(l - 1, 0);
            end else begin
                l = $urandom_range(255);
                h = l + $urandom_range(40);
                if (h > 255) h = 255;
            end
            lo[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W] = l[irbf_pkg::OCTET_W-1:0];
            hi[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W] = h[irbf_pkg::OCTET_W-1:0];
        end
        if ($urandom_range(99) < 20) hi = lo;
    endtask

    function automatic logic [irbf_pkg::ADDR_W-1:0] addr_in(logic [irbf_pkg::ADDR_W-1:0] lo,
                                                            logic [irbf_pkg::ADDR_W-1:0] hi);
        logic [irbf_pkg::ADDR_W-1:0]  a;
        logic [irbf_pkg::OCTET_W-1:0] l, h;
        int unsigned                  v;
        for (int k = 0; k < irbf_pkg::OCTETS; k++) begin
            l = lo[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W];
            h = hi[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W];
            v = (l <= h) ? $urandom_range(h, l) : 32'(l);
            a[k*irbf_pkg::OCTET_W +: irbf_pkg::OCTET_W] = v[irbf_pkg::OCTET_W-1:0];
        end
        return a;
    endfunction

    task random_beats(int unsigned count);
        int unsigned                 r, pick;
        logic [irbf_pkg::ADDR_W-1:0] lo, hi;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                send_beat(irbf_pkg::ACT_CLEAR, $urandom, $urandom);
            end else if (r < 4) begin
                send_beat(irbf_pkg::ACT_NONE, $urandom, $urandom);
            end else if (r < 46) begin
                if (seen_lo.size() != 0 && $urandom_range(99) < 15) begin
                    pick = $urandom_range(seen_lo.size() - 1);
                    lo = seen_lo[pick];
                    hi = seen_hi[pick];
                end else begin
                    make_range(lo, hi);
                    seen_lo.push_back(lo);
                    seen_hi.push_back(hi);
                    if (seen_lo.size() > 32) begin
                        void'(seen_lo.pop_front());
                        void'(seen_hi.pop_front());
                    end
                end
                send_beat(irbf_pkg::ACT_INSERT, lo, hi);
            end else begin
                if (seen_lo.size() != 0 && $urandom_range(99) < 60) begin
                    pick = $urandom_range(seen_lo.size() - 1);
                    lo = addr_in(seen_lo[pick], seen_hi[pick]);
                end else begin
                    lo = $urandom;
                end
                send_beat(irbf_pkg::ACT_CHECK, lo, $urandom);
            end
        end
    endtask

    task directed_beats();
        send_beat(irbf_pkg::ACT_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(irbf_pkg::ACT_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(irbf_pkg::ACT_INSERT, 32'h0A01_0203, 32'h0A01_0203);
        send_beat(irbf_pkg::ACT_CHECK, 32'h0A01_0203, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_CHECK, 32'h0A01_0204, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_INSERT, 32'h0A01_0203, 32'h0A01_0203);
        // inverted third octet, never matches
        send_beat(irbf_pkg::ACT_INSERT, 32'h0102_0304, 32'h0102_0204);
        send_beat(irbf_pkg::ACT_CHECK, 32'h0102_0304, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(irbf_pkg::ACT_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
        // fill the table to the last slot
        for (int k = 0; k < TABLE_DEPTH - 5; k++)
            send_beat(irbf_pkg::ACT_INSERT, {8'(20 + k), 24'h00_0000},
                      {8'(20 + k), 24'h80_FFFF});
        send_beat(irbf_pkg::ACT_INSERT, 32'hC0A8_0000, 32'hC0A8_FFFF);
        // full: new entry dropped, duplicate still fine
        send_beat(irbf_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(irbf_pkg::ACT_INSERT, 32'hC0A8_0000, 32'hC0A8_FFFF);
        send_beat(irbf_pkg::ACT_CHECK, 32'hC0A8_1234, 32'h0000_0000);
        send_beat(irbf_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(irbf_pkg::ACT_CHECK, 32'hC0A8_1234, 32'h0000_0000);
    endtask

    initial begin
        idle_pct = 34;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_beats();
        random_beats(125);
        idle_pct = 81;
        random_beats(125);
        idle_pct = 0;
        random_beats(125);
        start <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && sb.verdict_q.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
